// ===== hw/rtl/sle_pkg.sv =====
package sle_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_scan_state;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    // command from the front end that starts one line evaluation
    typedef struct packed {
        logic       start;
        logic       enable;
        logic       half;
        logic [7:0] line;
        logic [7:0] count;
    } t_eval_cmd;

    localparam int WORD_W = 32;
    localparam int Y_LSB  = 16;
    localparam int Y_MSB  = 23;

endpackage

// ===== hw/rtl/sle_attr_mem.sv =====
module sle_attr_mem #(
    parameter int AW = 7
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW:0]               i_waddr,
    input  logic [sle_pkg::WORD_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW:0]               i_raddr,
    output logic [sle_pkg::WORD_W-1:0] o_rdata
);
    import sle_pkg::*;

    localparam int DEPTH = 2 << AW;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sle_scan.sv =====
module sle_scan #(
    parameter int MAX_PER_LINE  = 32,
    parameter int SPRITE_HEIGHT = 8,
    parameter int AW            = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sle_pkg::t_eval_cmd         i_cmd,
    input  logic [sle_pkg::WORD_W-1:0] i_rdata,
    input  logic                       i_out_stall,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [AW:0]                o_rd_addr,
    output logic                       o_out_valid,
    output logic [sle_pkg::WORD_W-1:0] o_sprite_word,
    output logic [4:0]                 o_slot,
    output logic                       o_last,
    output logic                       o_none_found
);
    import sle_pkg::*;

    localparam int         LIM      = (MAX_PER_LINE < 32) ? MAX_PER_LINE : 32;
    localparam logic [5:0] LIM_V    = 6'(LIM);
    localparam logic [7:0] DIST_MAX = 8'(SPRITE_HEIGHT - 1);

    t_scan_state r_state, n_state;

    logic              r_half, n_half;
    logic [7:0]        r_line, n_line;
    logic [7:0]        r_n, n_n;
    logic [7:0]        r_idx, n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic [5:0]        r_found, n_found;
    logic              r_pend_vld, n_pend_vld;
    logic [WORD_W-1:0] r_pend_word, n_pend_word;
    logic [4:0]        r_pend_slot, n_pend_slot;
    logic              r_out_vld, n_out_vld;
    logic [WORD_W-1:0] r_out_word, n_out_word;
    logic [4:0]        r_out_slot, n_out_slot;
    logic              r_out_last, n_out_last;
    logic              r_out_none, n_out_none;

    logic [7:0] y_delta;
    logic       hit;
    logic       out_free;
    logic       blocked;
    logic       cap;
    logic       issue;
    logic       scan_done;

    always_comb begin
        y_delta  = r_line - i_rdata[Y_MSB:Y_LSB];
        hit      = r_rd_vld && (y_delta <= DIST_MAX) && (r_found < LIM_V);
        out_free = !r_out_vld || !i_out_stall;
        // a new hit must push the held one out, so wait for the output slot
        blocked  = hit && r_pend_vld && !out_free;
        cap      = (r_found == LIM_V);
        issue    = (r_state == S_SCAN) && !blocked && (r_idx < r_n) && !cap;
        scan_done = (r_state == S_SCAN) && !r_rd_vld && ((r_idx >= r_n) || cap);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_state = (i_cmd.enable && (i_cmd.count != 8'd0)) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy    = (r_state != S_IDLE);
        o_rd_en   = issue;
        o_rd_addr = {r_half, r_idx[AW-1:0]};
    end

    always_comb begin
        n_half      = r_half;
        n_line      = r_line;
        n_n         = r_n;
        n_idx       = r_idx;
        n_found     = r_found;
        n_pend_vld  = r_pend_vld;
        n_pend_word = r_pend_word;
        n_pend_slot = r_pend_slot;
        n_out_vld   = out_free ? 1'b0 : r_out_vld;
        n_out_word  = r_out_word;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        n_out_none  = r_out_none;
        n_rd_vld    = blocked ? r_rd_vld : issue;

        if (issue) begin
            n_idx = r_idx + 8'd1;
        end

        if ((r_state == S_IDLE) && i_cmd.start) begin
            n_half     = i_cmd.half;
            n_line     = i_cmd.line;
            n_n        = i_cmd.count;
            n_idx      = 8'd0;
            n_found    = 6'd0;
            n_pend_vld = 1'b0;
        end

        // the newest hit is held back until it is known whether it is the last
        if (hit && !blocked) begin
            if (r_pend_vld) begin
                n_out_vld  = 1'b1;
                n_out_word = r_pend_word;
                n_out_slot = r_pend_slot;
                n_out_last = 1'b0;
                n_out_none = 1'b0;
            end
            n_pend_vld  = 1'b1;
            n_pend_word = i_rdata;
            n_pend_slot = r_found[4:0];
            n_found     = r_found + 6'd1;
        end

        if ((r_state == S_FINISH) && out_free) begin
            n_out_vld  = 1'b1;
            n_out_word = r_pend_vld ? r_pend_word : '0;
            n_out_slot = r_pend_vld ? r_pend_slot : 5'd0;
            n_out_last = 1'b1;
            n_out_none = !r_pend_vld;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_found    <= 6'd0;
            r_idx      <= 8'd0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_found    <= n_found;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_half      <= n_half;
        r_line      <= n_line;
        r_n         <= n_n;
        r_pend_word <= n_pend_word;
        r_pend_slot <= n_pend_slot;
        r_out_word  <= n_out_word;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
        r_out_none  <= n_out_none;
    end

    assign o_out_valid   = r_out_vld;
    assign o_sprite_word = r_out_word;
    assign o_slot        = r_out_slot;
    assign o_last        = r_out_last;
    assign o_none_found  = r_out_none;

endmodule

// ===== hw/rtl/sprite_line_evaluator.sv =====
// load: the next item can be taken in the following cycle
// evaluate: one stored entry is read per cycle while the output does not stall; reading stops
// early once the per-line limit is reached, and a disabled or empty line reads no entry
// one item is in work at a time; input stall is high until the last beat is registered
// synchronous active-low reset clears control, entry count and enable; memory is not cleared
module sprite_line_evaluator #(
    parameter int MAX_PER_LINE  = 32,
    parameter int STORE_ENTRIES = 128,
    parameter int SPRITE_HEIGHT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic        i_field,
    input  logic [6:0]  i_entry_index,
    input  logic [31:0] i_entry_word,
    input  logic [7:0]  i_sprite_total,
    input  logic [7:0]  i_line,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_sprite_word,
    output logic [4:0]  o_slot,
    output logic        o_last,
    output logic        o_none_found
);
    import sle_pkg::*;

    localparam int         AW     = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
    localparam logic [7:0] SE_MAX = 8'(STORE_ENTRIES);

    logic        r_enable;
    logic [7:0]  r_count, n_count;
    logic        busy;
    logic        in_acc;
    logic        load;
    logic        mem_we;
    logic [AW:0] waddr;
    logic        rd_en;
    logic [AW:0] rd_addr;
    logic [WORD_W-1:0] rdata;
    t_eval_cmd   cmd;

    always_comb begin
        in_acc  = i_in_valid && !busy;
        load    = in_acc && (t_op'(i_op) == OP_LOAD);
        mem_we  = load && ({1'b0, i_entry_index} < SE_MAX);
        waddr   = {i_field, i_entry_index[AW-1:0]};
        n_count = load ? ((i_sprite_total > SE_MAX) ? SE_MAX : i_sprite_total) : r_count;

        cmd.start  = in_acc && (t_op'(i_op) == OP_EVAL);
        cmd.enable = r_enable;
        cmd.half   = !i_field;
        cmd.line   = i_line;
        cmd.count  = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_count  <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            r_count <= n_count;
        end
    end

    sle_attr_mem #(
        .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (i_entry_word),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    sle_scan #(
        .MAX_PER_LINE  (MAX_PER_LINE),
        .SPRITE_HEIGHT (SPRITE_HEIGHT),
        .AW            (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rdata       (rdata),
        .i_out_stall   (i_out_stall),
        .o_busy        (busy),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_out_valid   (o_out_valid),
        .o_sprite_word (o_sprite_word),
        .o_slot        (o_slot),
        .o_last        (o_last),
        .o_none_found  (o_none_found)
    );

    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

endmodule
